>>> hdl/shortest_job_first_heap_assert.svh
// assertion macros used by the checker file
`ifndef SHORTEST_JOB_FIRST_HEAP_ASSERT_SVH
`define SHORTEST_JOB_FIRST_HEAP_ASSERT_SVH

// same-cycle implication, off while reset is held
`define SJF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define SJF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define SJF_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sjf_pkg.sv
// types and constants of the shortest-job-first heap scheduler
package sjf_pkg;

  localparam int BURST_W   = 16;
  localparam int JOB_ID_W  = 6;
  localparam int ELAPSED_W = 22;

  // one arriving job
  typedef struct packed {
    logic [BURST_W-1:0] burst_time;
    logic               is_last;
  } sjf_in_t;

  // one scheduled job
  typedef struct packed {
    logic [JOB_ID_W-1:0]  job_id;
    logic [BURST_W-1:0]   job_burst;
    logic [ELAPSED_W-1:0] elapsed_time;
    logic                 dropped;
    logic                 run_end;
  } sjf_out_t;

  // heap entry as held in the store
  typedef struct packed {
    logic [JOB_ID_W-1:0] job_id;
    logic [BURST_W-1:0]  burst;
  } sjf_entry_t;

  localparam int ENTRY_W = $bits(sjf_entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLD_RD,
    S_BLD_LD,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_POP_RD,
    S_POP_EM
  } sjf_state_t;

endpackage

>>> hdl/sjf_ram.sv
// heap store: one write port, two registered read ports
module sjf_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  sjf_pkg::sjf_entry_t  wr_data,
  input  logic [AW-1:0]        rd_addr_a,
  input  logic [AW-1:0]        rd_addr_b,
  output sjf_pkg::sjf_entry_t  rd_data_a,
  output sjf_pkg::sjf_entry_t  rd_data_b
);

  sjf_pkg::sjf_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> hdl/shortest_job_first_heap.sv
// shortest-job-first scheduler on a binary min-heap held in a block memory
//
// Input: a job is taken at a clock edge with start high and busy low. It
// carries a 16-bit burst time; jobs are numbered in arrival order. The job
// with is_last set closes the batch. Jobs past JOB_SLOTS are discarded and
// the whole batch is then flagged as dropped.
// Jobs can be loaded back to back; busy stays low between jobs of a batch.
// On the closing job busy rises and the block builds the heap bottom-up,
// then pops the jobs shortest first. Each result appears on out_res for one
// cycle with out_valid high, giving job id, burst, running elapsed time,
// the dropped flag and run_end on the last job of the batch.
// Every sift level is a memory read, then a compare and write back, as
// the read ports of the heap store are registered; a sift ends by
// writing the element at a leaf or where it stops moving. The receiver
// cannot stall, so results are never held back. The final result shows
// in the cycle busy falls.
// Reset clears the job count, flags and the control state; the store
// itself needs no clearing since only entries written in a batch are used.
module shortest_job_first_heap #(
  parameter int JOB_SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sjf_pkg::sjf_in_t   in_item,
  output logic               out_valid,
  output sjf_pkg::sjf_out_t  out_res
);

  localparam int AW   = $clog2(JOB_SLOTS);
  localparam int CW   = $clog2(JOB_SLOTS + 1);
  localparam int CMPW = AW + 2;

  sjf_pkg::sjf_state_t state_r, state_nxt;

  logic [CW-1:0]                   count_r, count_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [sjf_pkg::ELAPSED_W-1:0]   elapsed_r, elapsed_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic [AW-1:0]                   pos_r, pos_nxt;
  logic [CW-1:0]                   size_r, size_nxt;
  sjf_pkg::sjf_entry_t             elem_r, elem_nxt;
  logic                            popping_r, popping_nxt;
  logic                            out_valid_r, out_valid_nxt;
  sjf_pkg::sjf_out_t               out_res_r, out_res_nxt;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  sjf_pkg::sjf_entry_t  wr_data;
  logic [AW-1:0]        rd_addr_a;
  logic [AW-1:0]        rd_addr_b;
  sjf_pkg::sjf_entry_t  rd_data_a;
  sjf_pkg::sjf_entry_t  rd_data_b;

  logic                 accept;
  logic                 has_room;
  logic [CW-1:0]        count_inc;
  logic [CMPW-1:0]      child_c;
  logic [CMPW-1:0]      right_c;
  logic [CMPW-1:0]      size_c;
  logic                 take_right;
  sjf_pkg::sjf_entry_t  sel_e;
  logic [CMPW-1:0]      sel_idx;
  logic                 sift_leaf;
  logic                 sift_move;

  sjf_ram #(
    .DEPTH (JOB_SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // request handshake and load bookkeeping
  assign accept    = start && !busy;
  assign has_room  = (count_r < CW'(JOB_SLOTS));
  assign count_inc = count_r + CW'(1);

  // children of the node being placed
  assign child_c    = CMPW'({pos_r, 1'b1});
  assign right_c    = child_c + CMPW'(1);
  assign size_c     = CMPW'(size_r);
  assign sift_leaf  = (child_c >= size_c);
  assign take_right = (right_c < size_c) && (rd_data_a.burst > rd_data_b.burst);
  assign sel_e      = take_right ? rd_data_b : rd_data_a;
  assign sel_idx    = take_right ? right_c : child_c;
  assign sift_move  = (elem_r.burst > sel_e.burst);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sjf_pkg::S_IDLE: begin
        if (accept && in_item.is_last) begin
          state_nxt = sjf_pkg::S_BLD_RD;
        end
      end
      sjf_pkg::S_BLD_RD: begin
        state_nxt = sjf_pkg::S_BLD_LD;
      end
      sjf_pkg::S_BLD_LD: begin
        state_nxt = sjf_pkg::S_SIFT_RD;
      end
      sjf_pkg::S_SIFT_RD: begin
        if (!sift_leaf) begin
          state_nxt = sjf_pkg::S_SIFT_CMP;
        end else if (popping_r || idx_r == '0) begin
          state_nxt = sjf_pkg::S_POP_RD;
        end else begin
          state_nxt = sjf_pkg::S_BLD_RD;
        end
      end
      sjf_pkg::S_SIFT_CMP: begin
        if (sift_move) begin
          state_nxt = sjf_pkg::S_SIFT_RD;
        end else if (popping_r || idx_r == '0) begin
          state_nxt = sjf_pkg::S_POP_RD;
        end else begin
          state_nxt = sjf_pkg::S_BLD_RD;
        end
      end
      sjf_pkg::S_POP_RD: begin
        state_nxt = sjf_pkg::S_POP_EM;
      end
      sjf_pkg::S_POP_EM: begin
        if (idx_r == CW'(1)) begin
          state_nxt = sjf_pkg::S_IDLE;
        end else begin
          state_nxt = sjf_pkg::S_SIFT_RD;
        end
      end
      default: begin
        state_nxt = sjf_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    elapsed_nxt   = elapsed_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    size_nxt      = size_r;
    elem_nxt      = elem_r;
    popping_nxt   = popping_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = elem_r;
    rd_addr_a     = AW'(idx_r);
    rd_addr_b     = AW'(child_c + CMPW'(1));
    unique case (state_r)
      sjf_pkg::S_IDLE: begin
        // store the arriving job or mark the batch as overfull
        if (accept) begin
          if (has_room) begin
            wr_en     = 1'b1;
            wr_addr   = AW'(count_r);
            wr_data   = '{job_id: sjf_pkg::JOB_ID_W'(count_r),
                          burst:  in_item.burst_time};
            count_nxt = count_inc;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_item.is_last) begin
            popping_nxt = 1'b0;
            idx_nxt     = ((has_room ? count_inc : count_r) - CW'(1)) >> 1;
          end
        end
      end
      sjf_pkg::S_BLD_RD: begin
        rd_addr_a = AW'(idx_r);
      end
      sjf_pkg::S_BLD_LD: begin
        elem_nxt = rd_data_a;
        pos_nxt  = AW'(idx_r);
        size_nxt = count_r;
      end
      sjf_pkg::S_SIFT_RD: begin
        // fetch both children, or settle at a leaf
        rd_addr_a = AW'(child_c);
        rd_addr_b = AW'(right_c);
        if (sift_leaf) begin
          wr_en = 1'b1;
        end
      end
      sjf_pkg::S_SIFT_CMP: begin
        wr_en = 1'b1;
        if (sift_move) begin
          wr_data = sel_e;
          pos_nxt = AW'(sel_idx);
        end
      end
      sjf_pkg::S_POP_RD: begin
        // root and last element of the heap
        rd_addr_a = '0;
        rd_addr_b = AW'(idx_r - CW'(1));
      end
      sjf_pkg::S_POP_EM: begin
        elapsed_nxt   = elapsed_r + sjf_pkg::ELAPSED_W'(rd_data_a.burst);
        out_valid_nxt = 1'b1;
        out_res_nxt   = '{job_id:       rd_data_a.job_id,
                          job_burst:    rd_data_a.burst,
                          elapsed_time: elapsed_nxt,
                          dropped:      ovf_r,
                          run_end:      (idx_r == CW'(1))};
        elem_nxt      = rd_data_b;
        pos_nxt       = '0;
        size_nxt      = idx_r - CW'(1);
        if (idx_r == CW'(1)) begin
          count_nxt   = '0;
          ovf_nxt     = 1'b0;
          elapsed_nxt = '0;
          popping_nxt = 1'b0;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase

    // loop counter moves on when a sift finishes
    if ((state_r == sjf_pkg::S_SIFT_RD && sift_leaf) ||
        (state_r == sjf_pkg::S_SIFT_CMP && !sift_move)) begin
      if (popping_r) begin
        idx_nxt = idx_r - CW'(1);
      end else if (idx_r == '0) begin
        popping_nxt = 1'b1;
        idx_nxt     = count_r;
      end else begin
        idx_nxt = idx_r - CW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sjf_pkg::S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      elapsed_r   <= '0;
      popping_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      elapsed_r   <= elapsed_nxt;
      popping_r   <= popping_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    size_r    <= size_nxt;
    elem_r    <= elem_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != sjf_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> hdl/sjf_checker.sv
// port-level checks for the shortest-job-first heap scheduler
`include "shortest_job_first_heap_assert.svh"

module sjf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input sjf_pkg::sjf_in_t   in_item,
  input logic               out_valid,
  input sjf_pkg::sjf_out_t  out_res
);

  // reset leaves the block idle with no result
  `SJF_ASSERT_ALWAYS_NXT(a_reset_idle, clk, !rst_n, !busy && !out_valid, "not idle after reset")

  // a closing request starts scheduling
  `SJF_ASSERT_NXT(a_close_busy, clk, rst_n, start && !busy && in_item.is_last, busy, "no busy after closing request")

  // a non-closing request gives no result and leaves the block ready
  `SJF_ASSERT_NXT(a_load_ready, clk, rst_n, start && !busy && !in_item.is_last, !busy && !out_valid, "load request disturbed the block")

  // results never come in adjacent cycles
  `SJF_ASSERT_NXT(a_strobe_gap, clk, rst_n, out_valid, !out_valid, "back-to-back result strobes")

  // elapsed time includes the job's own burst
  `SJF_ASSERT_IMP(a_elapsed, clk, rst_n, out_valid, out_res.elapsed_time >= sjf_pkg::ELAPSED_W'(out_res.job_burst), "elapsed below burst")

endmodule

bind shortest_job_first_heap sjf_checker u_sjf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_res   (out_res)
);

>>> tb/sv/shortest_job_first_heap_tb.sv
// testbench of the shortest-job-first heap scheduler: job batches checked against a heap predictor
module shortest_job_first_heap_tb;
  import sjf_pkg::*;

  localparam int JOB_SLOTS    = 32;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;

  // burst patterns used by the random batches
  typedef enum int {
    MIX_FULL,
    MIX_TIES,
    MIX_EXTREME,
    MIX_HIGH
  } burst_mix_t;

  // predicts the pop order of each batch and holds the results still due
  class sjf_schedule_board;
    int         slots;
    sjf_entry_t heap[];
    int         held;
    bit         overflow;
    sjf_out_t   due_jobs[$];
    int         errors;
    int         results;
    int         batches;
    int         overfull_batches;

    function new(int n);
      slots = n;
      heap = new[n];
      held = 0;
      overflow = 1'b0;
      errors = 0;
      results = 0;
      batches = 0;
      overfull_batches = 0;
    endfunction

    // place entry e at node pos of an n-entry heap
    function void sift_down(int pos, int n, sjf_entry_t e);
      int parent;
      int child;
      bit placed;
      parent = pos;
      child = 2 * pos + 1;
      placed = 1'b0;
      while (child < n && !placed) begin
        if (child + 1 < n && heap[child].burst > heap[child + 1].burst) child++;
        if (e.burst > heap[child].burst) begin
          heap[parent] = heap[child];
          parent = child;
          child = 2 * child + 1;
        end else begin
          placed = 1'b1;
        end
      end
      heap[parent] = e;
    endfunction

    // build the heap over the batch, then pop it shortest first
    function void schedule_batch();
      int n;
      logic [ELAPSED_W-1:0] elapsed;
      sjf_entry_t top;
      sjf_out_t r;
      n = held;
      for (int i = (n - 1) / 2; i >= 0; i--) sift_down(i, n, heap[i]);
      elapsed = '0;
      for (int i = n; i > 0; i--) begin
        top = heap[0];
        elapsed = elapsed + ELAPSED_W'(top.burst);
        r.job_id = top.job_id;
        r.job_burst = top.burst;
        r.elapsed_time = elapsed;
        r.dropped = overflow;
        r.run_end = (i == 1);
        due_jobs.push_back(r);
        if (i > 1) sift_down(0, i - 1, heap[i - 1]);
      end
      batches++;
      if (overflow) overfull_batches++;
      held = 0;
      overflow = 1'b0;
    endfunction

    // an accepted request: store or drop the job, schedule on the closing one
    function void take_job(sjf_in_t j);
      sjf_entry_t e;
      if (held < slots) begin
        e.job_id = JOB_ID_W'(held);
        e.burst = j.burst_time;
        heap[held] = e;
        held++;
      end else begin
        overflow = 1'b1;
      end
      if (j.is_last) schedule_batch();
    endfunction

    // compare one result with the oldest one due
    function void check_job(sjf_out_t got);
      sjf_out_t want;
      results++;
      if (due_jobs.size() == 0) begin
        $error("unexpected result: job_id %0d job_burst %0d", got.job_id, got.job_burst);
        errors++;
        return;
      end
      want = due_jobs.pop_front();
      if (got.job_id !== want.job_id) begin
        $error("job_id: expected %0d, actual %0d", want.job_id, got.job_id);
        errors++;
      end
      if (got.job_burst !== want.job_burst) begin
        $error("job_burst: expected %0d, actual %0d", want.job_burst, got.job_burst);
        errors++;
      end
      if (got.elapsed_time !== want.elapsed_time) begin
        $error("elapsed_time: expected %0d, actual %0d", want.elapsed_time, got.elapsed_time);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped: expected %0d, actual %0d", want.dropped, got.dropped);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end: expected %0d, actual %0d", want.run_end, got.run_end);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  sjf_in_t   in_item;
  logic      out_valid;
  sjf_out_t  out_res;

  sjf_schedule_board board = new(JOB_SLOTS);
  int jobs_taken = 0;
  int cycles = 0;

  shortest_job_first_heap #(
    .JOB_SLOTS(JOB_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_res(out_res)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // accepted requests feed the predictor
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      board.take_job(in_item);
      jobs_taken++;
    end
  end

  // results are checked as they appear
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_job(out_res);
  end

  // hold the request line low; n sets how long
  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // present one job and wait until it is taken
  task automatic send_job(logic [BURST_W-1:0] burst, logic last);
    sjf_in_t j;
    j.burst_time = burst;
    j.is_last = last;
    @(negedge clk);
    start <= 1'b1;
    in_item <= j;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [BURST_W-1:0] pick_burst(burst_mix_t mix);
    case (mix)
      MIX_TIES:    return BURST_W'($urandom_range(7));
      MIX_EXTREME: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      MIX_HIGH:    return 16'hFFFF - BURST_W'($urandom_range(15));
      default:     return BURST_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // random batches, mostly small, some full and some over capacity
  task automatic run_phase(int items, int idle_pct, bit over_first);
    int sent;
    int size;
    int pick;
    burst_mix_t mix;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if ((over_first && sent == 0) || pick >= 90)
        size = $urandom_range(JOB_SLOTS + 8, JOB_SLOTS + 1);
      else if (pick < 65)
        size = $urandom_range(8, 1);
      else
        size = $urandom_range(JOB_SLOTS, 9);
      mix = burst_mix_t'($urandom_range(3));
      for (int k = 0; k < size; k++) begin
        if ($urandom_range(99) < idle_pct) idle_for($urandom_range(4, 1));
        send_job(pick_burst(mix), k == size - 1);
      end
      sent += size;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-job batches at both burst extremes
    send_job(16'h0000, 1'b1);
    send_job(16'hFFFF, 1'b1);
    // all bursts equal
    repeat (4) send_job(16'd100, 1'b0);
    send_job(16'd100, 1'b1);
    // descending bursts across the full range
    send_job(16'hFFFF, 1'b0);
    send_job(16'd40000, 1'b0);
    send_job(16'd300, 1'b0);
    send_job(16'd1, 1'b0);
    send_job(16'h0000, 1'b1);
    // interleaved ties
    send_job(16'd7, 1'b0);
    send_job(16'd3, 1'b0);
    send_job(16'd7, 1'b0);
    send_job(16'd3, 1'b0);
    send_job(16'd7, 1'b0);
    send_job(16'd3, 1'b1);
    // two equal jobs
    send_job(16'd5, 1'b0);
    send_job(16'd5, 1'b1);

    run_phase(90, 31, 1'b1);
    run_phase(90, 58, 1'b0);
    run_phase(90, 0, 1'b0);

    @(negedge clk);
    start <= 1'b0;
    while (board.due_jobs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d jobs in %0d batches, %0d of them over capacity",
             jobs_taken, board.batches, board.overfull_batches);
    $display("checked %0d scheduled jobs with %0d mismatches", board.results, board.errors);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
